// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

	// field widths
	localparam int HUE_W = 24;
	localparam int LEVEL_FRAC_BITS = 16;
	localparam int LVL_W = LEVEL_FRAC_BITS + 1;
	localparam int HUE_FRAC_BITS = 6;

	// hue geometry
	localparam longint unsigned SECTOR_UNITS = longint'(60) << HUE_FRAC_BITS;
	localparam longint unsigned TURN_UNITS = 6 * SECTOR_UNITS;
	localparam longint unsigned LEVEL_ONE = longint'(1) << LEVEL_FRAC_BITS;

	// bias that makes any hue non-negative, a whole number of turns
	localparam longint unsigned HUE_NEG_MAX = longint'(1) << (HUE_W - 1);
	localparam longint unsigned HUE_BIAS =
		((HUE_NEG_MAX + TURN_UNITS - 1) / TURN_UNITS) * TURN_UNITS;
	localparam longint unsigned U_MAX = HUE_NEG_MAX - 1 + HUE_BIAS;
	localparam int U_W = $clog2(U_MAX + 1);

	// turn quotient by reciprocal, low by at most one
	localparam longint unsigned TURN_RECIP = (longint'(1) << U_W) / TURN_UNITS;
	localparam int TR_W = $clog2(TURN_RECIP + 1);
	localparam int Q_W = $clog2(U_MAX / TURN_UNITS + 1);
	localparam int R_W = $clog2(2 * TURN_UNITS);
	localparam int HW_W = $clog2(TURN_UNITS);
	localparam int REM_W = $clog2(SECTOR_UNITS);

	// sector quotient of sat * rem
	localparam longint unsigned X_MAX = LEVEL_ONE * (SECTOR_UNITS - 1);
	localparam int X_W = $clog2(X_MAX + 1);
	localparam longint unsigned SECTOR_RECIP = (longint'(1) << X_W) / SECTOR_UNITS;
	localparam int SR_W = $clog2(SECTOR_RECIP + 1);
	localparam int RX_W = $clog2(2 * SECTOR_UNITS);

	// sector codes
	localparam int SECT_W = 3;
	localparam logic [SECT_W-1:0] SEC_R_Y = 3'd0;
	localparam logic [SECT_W-1:0] SEC_Y_G = 3'd1;
	localparam logic [SECT_W-1:0] SEC_G_C = 3'd2;
	localparam logic [SECT_W-1:0] SEC_C_B = 3'd3;
	localparam logic [SECT_W-1:0] SEC_B_M = 3'd4;
	localparam logic [SECT_W-1:0] SEC_M_R = 3'd5;
	localparam int SECTORS = 6;

	// stream packing
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 48;
	localparam int CH_W = 8;

	typedef struct packed {
		logic mul;
		logic scl;
	} chan_en_t;

endpackage

// ===== rtl/hsv2rgb_chan.sv =====
module hsv2rgb_chan
	import hsv2rgb_pkg::*;
(
	input  logic             clk,
	input  chan_en_t         en,
	input  logic [LVL_W-1:0] val,
	input  logic [LVL_W-1:0] fac,
	output logic [CH_W-1:0]  ch
);

	logic [2*LVL_W-1:0] prod_s11;
	logic [2*LVL_W+7:0] scaled;
	logic [CH_W-1:0]    ch_s12;

	// 255 * p as (p << 8) - p, then drop both level fractions
	assign scaled = {prod_s11, 8'b0} - (2*LVL_W+8)'(prod_s11);

	always_ff @(posedge clk) begin
		if (en.mul) begin
			prod_s11 <= val * fac;
		end
		if (en.scl) begin
			ch_s12 <= scaled[2*LEVEL_FRAC_BITS+7:2*LEVEL_FRAC_BITS];
		end
	end

	assign ch = ch_s12;

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB color converter, one pixel per clock while the output is not stalled.
//
// Input stream (s_*): one word per pixel, tdata = hue (24b signed, 1/64 degree,
// any turn count), saturation (17b, Q1.16), brightness (17b, Q1.16). Levels
// above 1.0 clamp to 1.0; hue wraps exactly into [0,360).
// Output stream (m_*): red, green, blue bytes and packed_color = {r, g, b}.
//
// Thirteen register stages: bias/clamp, turn quotient by reciprocal, turn
// remainder, wrap correction, sector split, sat * rem, sector quotient by
// reciprocal, sector remainder, quotient correction, p/q/t factors, v * factor
// products, scale by 255, sector select into the output register.
// Throughput is one word per clock while the receiver keeps m_tready high, set
// by the fully pipelined datapath.
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles collapse and input keeps flowing while the
// output word waits. A receiver stall backs up stage by stage; s_tready drops
// only when all stages hold data. Nothing is lost or repeated.
// Reset clears every valid bit; datapath registers are not reset.
module hsv_to_rgb_converter_core
	import hsv2rgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [23:0] hue, [40:24] saturation, [57:41] brightness
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // [7:0] red, [15:8] green, [23:16] blue, [47:24] packed_color
);

	localparam int STAGES = 13;

	// handshake / valid chain
	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;
	logic [STAGES:1] vin;

	// input fields
	logic [HUE_W-1:0] hue;
	logic [LVL_W-1:0] sat_in;
	logic [LVL_W-1:0] val_in;

	assign hue    = s_tdata[HUE_W-1:0];
	assign sat_in = s_tdata[HUE_W+LVL_W-1:HUE_W];
	assign val_in = s_tdata[HUE_W+2*LVL_W-1:HUE_W+LVL_W];

	// stage advances when empty or when the stage after it (or the output) advances
	for (genvar k = 1; k <= STAGES; k++) begin : g_en
		assign en[k] = m_tready | ~(&vld_q[STAGES:k]);
	end

	assign vin = {vld_q[STAGES-1:1], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & vin) | (~en & vld_q);
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[STAGES];

	// stage 1: bias hue positive, clamp levels
	logic [U_W-1:0]   u_s1;
	logic [LVL_W-1:0] sat_s1, val_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			u_s1   <= {{(U_W-HUE_W){hue[HUE_W-1]}}, hue} + U_W'(HUE_BIAS);
			sat_s1 <= (sat_in > LVL_W'(LEVEL_ONE)) ? LVL_W'(LEVEL_ONE) : sat_in;
			val_s1 <= (val_in > LVL_W'(LEVEL_ONE)) ? LVL_W'(LEVEL_ONE) : val_in;
		end
	end

	// stage 2: turn count estimate
	logic [U_W+TR_W-1:0] tprod;
	logic [Q_W-1:0]      tq_s2;
	logic [U_W-1:0]      u_s2;
	logic [LVL_W-1:0]    sat_s2, val_s2;

	assign tprod = u_s1 * TR_W'(TURN_RECIP);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tq_s2  <= tprod[U_W+Q_W-1:U_W];
			u_s2   <= u_s1;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
	end

	// stage 3: remainder, below two turns
	logic [U_W-1:0]   tsub;
	logic [R_W-1:0]   r_s3;
	logic [LVL_W-1:0] sat_s3, val_s3;

	assign tsub = u_s2 - U_W'(tq_s2 * TURN_UNITS);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			r_s3   <= tsub[R_W-1:0];
			sat_s3 <= sat_s2;
			val_s3 <= val_s2;
		end
	end

	// stage 4: fix estimate that came out one low
	logic [R_W-1:0]   hw_full;
	logic [HW_W-1:0]  hw_s4;
	logic [LVL_W-1:0] sat_s4, val_s4;

	assign hw_full = (r_s3 >= R_W'(TURN_UNITS)) ? r_s3 - R_W'(TURN_UNITS) : r_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hw_s4  <= hw_full[HW_W-1:0];
			sat_s4 <= sat_s3;
			val_s4 <= val_s3;
		end
	end

	// stage 5: sector and offset within it
	logic [SECT_W-1:0] sect_d;
	logic [HW_W-1:0]   base_d;
	logic [HW_W-1:0]   rem_full;
	logic [SECT_W-1:0] sect_s5;
	logic [REM_W-1:0]  rem_s5;
	logic [LVL_W-1:0]  sat_s5, val_s5;

	always_comb begin
		sect_d = SEC_R_Y;
		base_d = '0;
		for (int k = 1; k < SECTORS; k++) begin
			if (hw_s4 >= HW_W'(k * SECTOR_UNITS)) begin
				sect_d = SECT_W'(k);
				base_d = HW_W'(k * SECTOR_UNITS);
			end
		end
	end

	assign rem_full = hw_s4 - base_d;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sect_s5 <= sect_d;
			rem_s5  <= rem_full[REM_W-1:0];
			sat_s5  <= sat_s4;
			val_s5  <= val_s4;
		end
	end

	// stage 6: s * rem
	logic [LVL_W+REM_W-1:0] xfull;
	logic [X_W-1:0]         x_s6;
	logic [SECT_W-1:0]      sect_s6;
	logic [LVL_W-1:0]       sat_s6, val_s6;

	assign xfull = sat_s5 * rem_s5;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			x_s6    <= xfull[X_W-1:0];
			sect_s6 <= sect_s5;
			sat_s6  <= sat_s5;
			val_s6  <= val_s5;
		end
	end

	// stage 7: x / sector estimate
	logic [X_W+SR_W-1:0] qprod;
	logic [LVL_W-1:0]    qe_s7;
	logic [X_W-1:0]      x_s7;
	logic [SECT_W-1:0]   sect_s7;
	logic [LVL_W-1:0]    sat_s7, val_s7;

	assign qprod = x_s6 * SR_W'(SECTOR_RECIP);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			qe_s7   <= qprod[X_W+LVL_W-1:X_W];
			x_s7    <= x_s6;
			sect_s7 <= sect_s6;
			sat_s7  <= sat_s6;
			val_s7  <= val_s6;
		end
	end

	// stage 8: remainder of that estimate
	logic [X_W-1:0]    rsub;
	logic [RX_W-1:0]   rx_s8;
	logic [LVL_W-1:0]  qe_s8;
	logic [SECT_W-1:0] sect_s8;
	logic [LVL_W-1:0]  sat_s8, val_s8;

	assign rsub = x_s7 - X_W'(qe_s7 * SECTOR_UNITS);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			rx_s8   <= rsub[RX_W-1:0];
			qe_s8   <= qe_s7;
			sect_s8 <= sect_s7;
			sat_s8  <= sat_s7;
			val_s8  <= val_s7;
		end
	end

	// stage 9: corrected floor and inexact flag (floor vs ceil for t)
	logic              fix;
	logic [RX_W-1:0]   rx_fix;
	logic [LVL_W-1:0]  qf_s9;
	logic              nz_s9;
	logic [SECT_W-1:0] sect_s9;
	logic [LVL_W-1:0]  sat_s9, val_s9;

	assign fix    = rx_s8 >= RX_W'(SECTOR_UNITS);
	assign rx_fix = fix ? rx_s8 - RX_W'(SECTOR_UNITS) : rx_s8;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			qf_s9   <= qe_s8 + LVL_W'(fix);
			nz_s9   <= rx_fix != '0;
			sect_s9 <= sect_s8;
			sat_s9  <= sat_s8;
			val_s9  <= val_s8;
		end
	end

	// stage 10: factors; t uses s*(D-rem)/D = s - ceil(s*rem/D)
	logic [LVL_W:0]    ftsum;
	logic [LVL_W-1:0]  fp_s10, fq_s10, ft_s10;
	logic [SECT_W-1:0] sect_s10;
	logic [LVL_W-1:0]  val_s10;

	assign ftsum = (LVL_W+1)'(LEVEL_ONE) - {1'b0, sat_s9} + {1'b0, qf_s9}
		+ (LVL_W+1)'(nz_s9);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			fp_s10   <= LVL_W'(LEVEL_ONE) - sat_s9;
			fq_s10   <= LVL_W'(LEVEL_ONE) - qf_s9;
			ft_s10   <= ftsum[LVL_W-1:0];
			sect_s10 <= sect_s9;
			val_s10  <= val_s9;
		end
	end

	// stages 11-12: v * factor, scale by 255
	chan_en_t        chan_en;
	logic [CH_W-1:0] cp, cq, ct;

	assign chan_en = '{mul: en[11], scl: en[12]};

	hsv2rgb_chan u_chan_p (.clk(clk), .en(chan_en), .val(val_s10), .fac(fp_s10), .ch(cp));
	hsv2rgb_chan u_chan_q (.clk(clk), .en(chan_en), .val(val_s10), .fac(fq_s10), .ch(cq));
	hsv2rgb_chan u_chan_t (.clk(clk), .en(chan_en), .val(val_s10), .fac(ft_s10), .ch(ct));

	// plain v channel needs no multiplier
	logic [LVL_W+7:0]  cvt;
	logic [CH_W-1:0]   cv_s11, cv_s12;
	logic [SECT_W-1:0] sect_s11, sect_s12;

	assign cvt = {val_s10, 8'b0} - (LVL_W+8)'(val_s10);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			cv_s11   <= cvt[LEVEL_FRAC_BITS+7:LEVEL_FRAC_BITS];
			sect_s11 <= sect_s10;
		end
		if (en[12]) begin
			cv_s12   <= cv_s11;
			sect_s12 <= sect_s11;
		end
	end

	// stage 13: pick channels by sector
	logic [CH_W-1:0] r_d, g_d, b_d;
	logic [CH_W-1:0] r_s13, g_s13, b_s13;

	always_comb begin
		unique case (sect_s12)
			SEC_R_Y: begin r_d = cv_s12; g_d = ct;     b_d = cp;     end
			SEC_Y_G: begin r_d = cq;     g_d = cv_s12; b_d = cp;     end
			SEC_G_C: begin r_d = cp;     g_d = cv_s12; b_d = ct;     end
			SEC_C_B: begin r_d = cp;     g_d = cq;     b_d = cv_s12; end
			SEC_B_M: begin r_d = ct;     g_d = cp;     b_d = cv_s12; end
			default: begin r_d = cv_s12; g_d = cp;     b_d = cq;     end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			r_s13 <= r_d;
			g_s13 <= g_d;
			b_s13 <= b_d;
		end
	end

	assign m_tdata = {r_s13, g_s13, b_s13, b_s13, g_s13, r_s13};

	// checks
	a_hue_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> hw_s4 < HW_W'(TURN_UNITS))
		else $error("wrapped hue not below one turn");

	a_rem_in_sector: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] |-> (rem_s5 < REM_W'(SECTOR_UNITS) && sect_s5 <= SEC_M_R))
		else $error("sector split out of range");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[10] |-> (ft_s10 <= LVL_W'(LEVEL_ONE) && fq_s10 <= LVL_W'(LEVEL_ONE)
			&& ft_s10 >= fp_s10 && fq_s10 >= fp_s10))
		else $error("p/q/t factor out of range");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !m_tready) |-> !s_tready)
		else $error("input accepted into a full stalled pipeline");

endmodule

// ===== tb/hsv_to_rgb_converter_core_test.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_test;
	import hsv2rgb_pkg::*;

	localparam int PIPE_LATENCY = 13;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int IDLE_PERCENT = 11;
	localparam int RANDOM_WORDS = 550;
	localparam int NUM_DIRECTED = 20;
	localparam longint RUN_LIMIT_NS = 2_000_000;

	// one output word, same field order as m_tdata from the top down
	typedef struct packed {
		logic [3*CH_W-1:0] packed_color;
		logic [CH_W-1:0]   blue;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   red;
	} rgb_word_t;

	// directed row; known marks rows whose colors are typed in
	typedef struct {
		int hue;
		int sat;
		int bri;
		bit known;
		int red;
		int green;
		int blue;
	} hsv_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [23:0] hue, [40:24] saturation, [57:41] brightness
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [47:24] packed_color

	rgb_word_t rgb_expected[$];     // colors still owed by the pipeline, oldest first
	int        err_count = 0;
	int        hold_requests = 0;   // bumped by the stimulus to ask for a long output stall
	bit        calm = 1'b0;         // no idling on either side while set

	hsv_to_rgb_converter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Channel with level factor f (units of 1/LEVEL_ONE), scaled by 255, truncated.
	function automatic logic [CH_W-1:0] scale_level(input longint unsigned v,
			input longint unsigned f);
		return CH_W'((longint'(255) * v * f) / (LEVEL_ONE * LEVEL_ONE));
	endfunction

	// Exact HSV to RGB: wrap hue into one turn, split into sector and remainder,
	// form p/q/t factors, then pick channels by sector.
	function automatic rgb_word_t predict_rgb(input logic [HUE_W-1:0] hue,
			input logic [LVL_W-1:0] sat, input logic [LVL_W-1:0] bri);
		longint            h_wrap;
		longint unsigned   s_lvl, v_lvl, rem;
		logic [SECT_W-1:0] sector;
		logic [CH_W-1:0]   ch_v, ch_p, ch_q, ch_t;
		rgb_word_t         w;
		s_lvl = (sat > LEVEL_ONE) ? LEVEL_ONE : longint'(sat);
		v_lvl = (bri > LEVEL_ONE) ? LEVEL_ONE : longint'(bri);
		h_wrap = longint'($signed(hue)) % longint'(TURN_UNITS);
		if (h_wrap < 0)
			h_wrap += longint'(TURN_UNITS);
		sector = SECT_W'(h_wrap / longint'(SECTOR_UNITS));
		rem = longint'(h_wrap % longint'(SECTOR_UNITS));
		ch_v = scale_level(v_lvl, LEVEL_ONE);
		ch_p = scale_level(v_lvl, LEVEL_ONE - s_lvl);
		ch_q = scale_level(v_lvl, LEVEL_ONE - (s_lvl * rem) / SECTOR_UNITS);
		ch_t = scale_level(v_lvl, LEVEL_ONE - (s_lvl * (SECTOR_UNITS - rem)) / SECTOR_UNITS);
		case (sector)
			SEC_R_Y: begin
				w.red = ch_v; w.green = ch_t; w.blue = ch_p;
			end
			SEC_Y_G: begin
				w.red = ch_q; w.green = ch_v; w.blue = ch_p;
			end
			SEC_G_C: begin
				w.red = ch_p; w.green = ch_v; w.blue = ch_t;
			end
			SEC_C_B: begin
				w.red = ch_p; w.green = ch_q; w.blue = ch_v;
			end
			SEC_B_M: begin
				w.red = ch_t; w.green = ch_p; w.blue = ch_v;
			end
			default: begin
				w.red = ch_v; w.green = ch_p; w.blue = ch_q;
			end
		endcase
		w.packed_color = {w.red, w.green, w.blue};
		return w;
	endfunction

	// Level mix: whole 17-bit range (above one too), the ends, and in-range values.
	function automatic logic [LVL_W-1:0] rand_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return LVL_W'(LEVEL_ONE);
			2, 3:    return LVL_W'($urandom);
			default: return LVL_W'($urandom_range(0, int'(LEVEL_ONE)));
		endcase
	endfunction

	// Offer one word, idling at random first; returns once it is accepted.
	// Called at a rising edge; valid stays high so back-to-back words flow.
	task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [LVL_W-1:0] sat,
			input logic [LVL_W-1:0] bri, input rgb_word_t want);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({bri, sat, hue});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rgb_expected.push_back(want);
	endtask

	// Output side: random stalls, plus one long hold when the stimulus asks.
	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Compare every accepted output word against the oldest owed color.
	always @(posedge clk) begin : result_check
		rgb_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rgb_expected.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				err_count++;
			end else begin
				want = rgb_expected.pop_front();
				if (m_tdata[0 +: CH_W] !== want.red) begin
					$error("red expected %0d got %0d", want.red, m_tdata[0 +: CH_W]);
					err_count++;
				end
				if (m_tdata[CH_W +: CH_W] !== want.green) begin
					$error("green expected %0d got %0d", want.green, m_tdata[CH_W +: CH_W]);
					err_count++;
				end
				if (m_tdata[2*CH_W +: CH_W] !== want.blue) begin
					$error("blue expected %0d got %0d", want.blue, m_tdata[2*CH_W +: CH_W]);
					err_count++;
				end
				if (m_tdata[3*CH_W +: 3*CH_W] !== want.packed_color) begin
					$error("packed_color expected %h got %h", want.packed_color,
						m_tdata[3*CH_W +: 3*CH_W]);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		hsv_row_t          directed_rows [NUM_DIRECTED];
		logic [HUE_W-1:0]  hue;
		logic [LVL_W-1:0]  sat, bri;
		rgb_word_t         want;
		longint            h_pick;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;

		// hue in 1/64 degree: 3840 = 60 deg, 23040 = one turn; 65536 = level 1.0
		directed_rows = '{
			'{0,        0,      0,      1'b1, 0,   0,   0  },  // black
			'{0,        0,      65536,  1'b1, 255, 255, 255},  // grey, full
			'{0,        0,      32768,  1'b1, 127, 127, 127},  // grey, half
			'{0,        65536,  65536,  1'b1, 255, 0,   0  },  // red
			'{3840,     65536,  65536,  1'b1, 255, 255, 0  },  // yellow
			'{7680,     65536,  65536,  1'b1, 0,   255, 0  },  // green
			'{11520,    65536,  65536,  1'b1, 0,   255, 255},  // cyan
			'{15360,    65536,  65536,  1'b1, 0,   0,   255},  // blue
			'{19200,    65536,  65536,  1'b1, 255, 0,   255},  // magenta
			'{0,        131071, 131071, 1'b1, 255, 0,   0  },  // levels above one clamp
			'{23040,    65536,  65536,  1'b1, 255, 0,   0  },  // one full turn
			'{-23040,   65536,  65536,  1'b1, 255, 0,   0  },  // minus one turn
			'{100000,   131071, 0,      1'b1, 0,   0,   0  },  // zero brightness
			'{1,        1,      1,      1'b1, 0,   0,   0  },  // tiny levels truncate
			'{8388607,  131071, 131071, 1'b0, 0,   0,   0  },  // most positive hue
			'{-8388608, 65536,  65536,  1'b0, 0,   0,   0  },  // most negative hue
			'{-1,       40000,  50000,  1'b0, 0,   0,   0  },  // just below zero
			'{3839,     65536,  65536,  1'b0, 0,   0,   0  },  // sector edge
			'{5000,     65535,  65535,  1'b0, 0,   0,   0  },
			'{23039,    12345,  65537,  1'b0, 0,   0,   0  }   // last unit of the turn
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			hue = HUE_W'(directed_rows[i].hue);
			sat = LVL_W'(directed_rows[i].sat);
			bri = LVL_W'(directed_rows[i].bri);
			if (directed_rows[i].known) begin
				want.red   = CH_W'(directed_rows[i].red);
				want.green = CH_W'(directed_rows[i].green);
				want.blue  = CH_W'(directed_rows[i].blue);
				want.packed_color = {want.red, want.green, want.blue};
			end else begin
				want = predict_rgb(hue, sat, bri);
			end
			send_hsv(hue, sat, bri, want);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// long output stall while input keeps coming: pipeline fills, s_tready drops
			if (n == 60)
				hold_requests++;
			// drain fully, then a stretch with no idling at all
			if (n == 200) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (rgb_expected.size() != 0)
					@(posedge clk);
				calm = 1'b1;
			end
			if (n == 350)
				calm = 1'b0;

			case ($urandom_range(0, 3))
				0: h_pick = longint'($urandom_range(0, int'(TURN_UNITS) - 1));
				1: h_pick = longint'($urandom_range(0, 5)) * longint'(SECTOR_UNITS)
					+ longint'($urandom_range(0, 4)) - 2
					+ (longint'($urandom_range(0, 40)) - 20) * longint'(TURN_UNITS);
				default: h_pick = longint'($urandom);
			endcase
			hue = HUE_W'(h_pick);
			sat = rand_level();
			bri = rand_level();
			send_hsv(hue, sat, bri, predict_rgb(hue, sat, bri));
		end

		s_tvalid <= 1'b0;
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		if (err_count == 0 && rgb_expected.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_chan.sv
rtl/hsv_to_rgb_converter_core.sv
tb/hsv_to_rgb_converter_core_test.sv
